FILE: rtl/scch_pkg.sv
// ----------------------------------------------------------------------------
// scch_pkg
// Types and constants shared by the capped cylinder hit core and its checker.
// ----------------------------------------------------------------------------
package scch_pkg;

  localparam int RW  = 49;                     // square root bits
  localparam int QW  = 97;                     // radicand bits
  localparam int QB  = 33;                     // quotient magnitude bits
  localparam int NST = 6 + RW + 7 + QB + 2;    // total register stages

  typedef enum logic [1:0] {
    FACE_BOTTOM = 2'd0,
    FACE_TOP    = 2'd1,
    FACE_SIDE   = 2'd2
  } face_e;

  typedef struct packed {
    logic               miss;
    logic               axial;
    logic [64:0]        a;
    logic signed [66:0] b;
    logic signed [31:0] z0;
    logic signed [31:0] t0;
    logic signed [32:0] dz;
    logic signed [32:0] dt;
  } geo_t;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic          dzero;
    logic [64:0]   den;
    logic [QB-1:0] nlo;
    logic [64:0]   rem;
    logic [QB-1:0] quo;
  } div_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t0;
    face_e              fin;
    face_e              fout;
  } res_t;

endpackage

FILE: rtl/segment_capped_cylinder_hit_core.sv
// ----------------------------------------------------------------------------
// segment_capped_cylinder_hit_core
// Line segment against unit capped cylinder: hit, entry/exit time and face.
// ----------------------------------------------------------------------------
// Depth: scch_pkg::NST register stages, from item accept to result valid.
// Throughput: one item per cycle while the output is not stalled; 49 square
// root stages and 33 divider stages, one result bit per stage, set the depth.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears the stage valid bits only; data registers are not reset.
module segment_capped_cylinder_hit_core import scch_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic signed [31:0] end_z_i,
  input  logic signed [31:0] start_param_i,
  input  logic signed [31:0] end_param_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic signed [31:0] entry_param_o,
  output logic signed [31:0] exit_param_o,
  output logic [1:0]         entry_face_o,
  output logic [1:0]         exit_face_o
);

  function automatic div_t div_step(input div_t d, input int bi);
    logic [65:0] sh;
    div_t        r;
    r  = d;
    sh = {d.rem, d.nlo[bi]};
    if (sh >= 66'(d.den)) begin
      sh       = sh - 66'(d.den);
      r.rem    = sh[64:0];
      r.quo[bi] = 1'b1;
    end else begin
      r.rem = sh[64:0];
    end
    return r;
  endfunction

  function automatic logic signed [34:0] quo_fix(input div_t d);
    logic signed [34:0] q;
    q = $signed(35'(d.quo));
    if (d.dzero) begin
      q = '0;
    end else if (d.ovf) begin
      q = d.neg ? -35'sh2_0000_0000 : 35'sh2_0000_0000;
    end else if (d.neg) begin
      q = (d.rem != '0) ? ~q : -q;
    end
    return q;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [31:0] t0,
                                              input logic signed [34:0] q);
    logic signed [35:0] s;
    s = 36'(t0) + 36'(q);
    if (s > 36'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -36'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return s[31:0];
  endfunction

  logic           en;
  logic [NST-1:0] vld_q;

  assign en          = !(vld_q[NST-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // stage 1: differences
  logic signed [31:0] s1_x0_q, s1_y0_q, s1_z0_q, s1_t0_q;
  logic signed [32:0] s1_dx_q, s1_dy_q, s1_dz_q, s1_dt_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x0_q <= start_x_i;
      s1_y0_q <= start_y_i;
      s1_z0_q <= start_z_i;
      s1_t0_q <= start_param_i;
      s1_dx_q <= 33'(end_x_i) - 33'(start_x_i);
      s1_dy_q <= 33'(end_y_i) - 33'(start_y_i);
      s1_dz_q <= 33'(end_z_i) - 33'(start_z_i);
      s1_dt_q <= 33'(end_param_i) - 33'(start_param_i);
    end
  end

  // stage 2: products
  logic signed [65:0] s2_dxx_q, s2_dyy_q, s2_xx_q, s2_yy_q;
  logic signed [65:0] s2_xdy_q, s2_ydx_q, s2_xdx_q, s2_ydy_q;
  logic signed [31:0] s2_z0_q, s2_t0_q;
  logic signed [32:0] s2_dz_q, s2_dt_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_dxx_q <= 66'(s1_dx_q) * 66'(s1_dx_q);
      s2_dyy_q <= 66'(s1_dy_q) * 66'(s1_dy_q);
      s2_xx_q  <= 66'(s1_x0_q) * 66'(s1_x0_q);
      s2_yy_q  <= 66'(s1_y0_q) * 66'(s1_y0_q);
      s2_xdy_q <= 66'(s1_x0_q) * 66'(s1_dy_q);
      s2_ydx_q <= 66'(s1_y0_q) * 66'(s1_dx_q);
      s2_xdx_q <= 66'(s1_x0_q) * 66'(s1_dx_q);
      s2_ydy_q <= 66'(s1_y0_q) * 66'(s1_dy_q);
      s2_z0_q  <= s1_z0_q;
      s2_t0_q  <= s1_t0_q;
      s2_dz_q  <= s1_dz_q;
      s2_dt_q  <= s1_dt_q;
    end
  end

  // stage 3: A, B, C, K
  logic signed [65:0] s3_asum;
  logic [64:0]        s3_a_q;
  logic signed [65:0] s3_c_q;
  logic signed [66:0] s3_k_q, s3_b_q;
  logic signed [31:0] s3_z0_q, s3_t0_q;
  logic signed [32:0] s3_dz_q, s3_dt_q;

  assign s3_asum = s2_dxx_q + s2_dyy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_a_q  <= s3_asum[64:0];
      s3_c_q  <= s2_xx_q + s2_yy_q - 66'sh1_0000_0000;
      s3_k_q  <= 67'(s2_xdy_q) - 67'(s2_ydx_q);
      s3_b_q  <= 67'(s2_xdx_q) + 67'(s2_ydy_q);
      s3_z0_q <= s2_z0_q;
      s3_t0_q <= s2_t0_q;
      s3_dz_q <= s2_dz_q;
      s3_dt_q <= s2_dt_q;
    end
  end

  // stage 4: early miss tests, |K|
  logic               s4_axial, s4_cpos, s4_kbig;
  logic signed [66:0] s4_kneg;
  geo_t               s4_g_q;
  logic [49:0]        s4_kabs_q;

  assign s4_axial = (s3_a_q == '0);
  assign s4_cpos  = !s3_c_q[65] && (s3_c_q != '0);
  assign s4_kneg  = -s3_k_q;
  assign s4_kbig  = s3_k_q[66] ? !(&s3_k_q[66:50] && |s3_k_q[49:0])
                               : |s3_k_q[66:50];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_g_q.miss  <= (s3_dt_q == '0) ||
                      (s4_axial ? (s4_cpos || s3_dz_q == '0) : s4_kbig);
      s4_g_q.axial <= s4_axial;
      s4_g_q.a     <= s3_a_q;
      s4_g_q.b     <= s3_b_q;
      s4_g_q.z0    <= s3_z0_q;
      s4_g_q.t0    <= s3_t0_q;
      s4_g_q.dz    <= s3_dz_q;
      s4_g_q.dt    <= s3_dt_q;
      s4_kabs_q    <= s3_k_q[66] ? s4_kneg[49:0] : s3_k_q[49:0];
    end
  end

  // stage 5: K^2 partial products
  logic [49:0] s5_khh_q, s5_khl_q, s5_kll_q;
  geo_t        s5_g_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_khh_q <= 50'(s4_kabs_q[49:25]) * 50'(s4_kabs_q[49:25]);
      s5_khl_q <= 50'(s4_kabs_q[49:25]) * 50'(s4_kabs_q[24:0]);
      s5_kll_q <= 50'(s4_kabs_q[24:0]) * 50'(s4_kabs_q[24:0]);
      s5_g_q   <= s4_g_q;
    end
  end

  // stage 6: quarter discriminant
  logic signed [100:0] s6_q;
  logic [QW-1:0]       s6_rad_q;
  geo_t                s6_g_q;

  assign s6_q = $signed(101'({s5_g_q.a, 32'd0}))
              - $signed((101'(s5_khh_q) << 50) + (101'(s5_khl_q) << 26) + 101'(s5_kll_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_rad_q    <= s6_q[100] ? '0 : s6_q[QW-1:0];
      s6_g_q      <= s5_g_q;
      s6_g_q.miss <= s5_g_q.miss || (!s5_g_q.axial && s6_q[100]);
    end
  end

  // square root, one bit per stage
  logic [QW-1:0] sq_rem_q  [RW];
  logic [RW-1:0] sq_root_q [RW];
  geo_t          sq_g_q    [RW];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int BB = RW - 1 - j;
    logic [QW-1:0] rin, trial;
    logic [RW-1:0] oin;
    geo_t          gin;
    if (j == 0) begin : g_first
      assign rin = s6_rad_q;
      assign oin = '0;
      assign gin = s6_g_q;
    end else begin : g_next
      assign rin = sq_rem_q[j-1];
      assign oin = sq_root_q[j-1];
      assign gin = sq_g_q[j-1];
    end
    assign trial = (QW'(oin) << (BB + 1)) | (QW'(1) << (2 * BB));
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (rin >= trial) begin
          sq_rem_q[j]  <= rin - trial;
          sq_root_q[j] <= oin | (RW'(1) << BB);
        end else begin
          sq_rem_q[j]  <= rin;
          sq_root_q[j] <= oin;
        end
        sq_g_q[j] <= gin;
      end
    end
  end

  // T1: side numerators, cap offsets
  logic signed [67:0] t1_r, t1_nb;
  logic signed [67:0] t1_ne_q, t1_nx_q;
  logic signed [32:0] t1_hb_q, t1_ht_q;
  geo_t               t1_g_q;

  assign t1_r  = $signed(68'(sq_root_q[RW-1]));
  assign t1_nb = -68'(sq_g_q[RW-1].b);

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_ne_q <= t1_nb - t1_r;
      t1_nx_q <= t1_nb + t1_r;
      t1_hb_q <= -33'(sq_g_q[RW-1].z0);
      t1_ht_q <= 33'sd65536 - 33'(sq_g_q[RW-1].z0);
      t1_g_q  <= sq_g_q[RW-1];
    end
  end

  // T2: partial products
  logic signed [34:0] t2_neh, t2_nxh;
  logic signed [33:0] t2_nel, t2_nxl, t2_al;
  logic signed [32:0] t2_ah;
  logic signed [67:0] t2_nezh_q, t2_nxzh_q, t2_neth_q, t2_nxth_q;
  logic signed [66:0] t2_nezl_q, t2_nxzl_q, t2_netl_q, t2_nxtl_q;
  logic signed [65:0] t2_zal_q, t2_capb_q, t2_capt_q;
  logic signed [64:0] t2_zah_q;
  geo_t               t2_g_q;

  assign t2_neh = $signed(t1_ne_q[67:33]);
  assign t2_nxh = $signed(t1_nx_q[67:33]);
  assign t2_nel = $signed({1'b0, t1_ne_q[32:0]});
  assign t2_nxl = $signed({1'b0, t1_nx_q[32:0]});
  assign t2_al  = $signed({1'b0, t1_g_q.a[32:0]});
  assign t2_ah  = $signed({1'b0, t1_g_q.a[64:33]});

  always_ff @(posedge clk_i) begin
    if (en) begin
      t2_nezh_q <= 68'(t2_neh) * 68'(t1_g_q.dz);
      t2_nxzh_q <= 68'(t2_nxh) * 68'(t1_g_q.dz);
      t2_neth_q <= 68'(t2_neh) * 68'(t1_g_q.dt);
      t2_nxth_q <= 68'(t2_nxh) * 68'(t1_g_q.dt);
      t2_nezl_q <= 67'(t2_nel) * 67'(t1_g_q.dz);
      t2_nxzl_q <= 67'(t2_nxl) * 67'(t1_g_q.dz);
      t2_netl_q <= 67'(t2_nel) * 67'(t1_g_q.dt);
      t2_nxtl_q <= 67'(t2_nxl) * 67'(t1_g_q.dt);
      t2_zal_q  <= 66'(t1_g_q.z0) * 66'(t2_al);
      t2_zah_q  <= 65'(t1_g_q.z0) * 65'(t2_ah);
      t2_capb_q <= 66'(t1_hb_q) * 66'(t1_g_q.dt);
      t2_capt_q <= 66'(t1_ht_q) * 66'(t1_g_q.dt);
      t2_g_q    <= t1_g_q;
    end
  end

  // T3: combine partial products
  logic signed [99:0] t3_nez_q, t3_nxz_q, t3_net_q, t3_nxt_q, t3_za_q;
  logic signed [65:0] t3_capb_q, t3_capt_q;
  geo_t               t3_g_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t3_nez_q  <= (100'(t2_nezh_q) <<< 33) + 100'(t2_nezl_q);
      t3_nxz_q  <= (100'(t2_nxzh_q) <<< 33) + 100'(t2_nxzl_q);
      t3_net_q  <= (100'(t2_neth_q) <<< 33) + 100'(t2_netl_q);
      t3_nxt_q  <= (100'(t2_nxth_q) <<< 33) + 100'(t2_nxtl_q);
      t3_za_q   <= (100'(t2_zah_q) <<< 33) + 100'(t2_zal_q);
      t3_capb_q <= t2_capb_q;
      t3_capt_q <= t2_capt_q;
      t3_g_q    <= t2_g_q;
    end
  end

  // T4: scaled heights of the side crossings
  logic signed [100:0] t4_ze_q, t4_zx_q;
  logic signed [99:0]  t4_net_q, t4_nxt_q;
  logic signed [65:0]  t4_capb_q, t4_capt_q;
  geo_t                t4_g_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t4_ze_q   <= 101'(t3_za_q) + 101'(t3_nez_q);
      t4_zx_q   <= 101'(t3_za_q) + 101'(t3_nxz_q);
      t4_net_q  <= t3_net_q;
      t4_nxt_q  <= t3_nxt_q;
      t4_capb_q <= t3_capb_q;
      t4_capt_q <= t3_capt_q;
      t4_g_q    <= t3_g_q;
    end
  end

  // T5: clip against caps, pick dividend and divisor per crossing
  logic signed [100:0] t5_one;
  logic                t5_zeg, t5_zen, t5_zxg, t5_zxn;
  logic signed [99:0]  t5_capb, t5_capt;
  logic signed [65:0]  t5_da, t5_dz;
  logic signed [99:0]  t5_nume_d, t5_numx_d;
  logic signed [65:0]  t5_dene_d, t5_denx_d;
  face_e               t5_fin_d, t5_fout_d;
  logic signed [99:0]  t5_nume_q, t5_numx_q;
  logic signed [65:0]  t5_dene_q, t5_denx_q;
  res_t                t5_res_q;

  assign t5_one  = $signed(101'({t4_g_q.a, 16'd0}));
  assign t5_zeg  = t4_ze_q > t5_one;
  assign t5_zen  = t4_ze_q[100];
  assign t5_zxg  = t4_zx_q > t5_one;
  assign t5_zxn  = t4_zx_q[100];
  assign t5_capb = 100'(t4_capb_q);
  assign t5_capt = 100'(t4_capt_q);
  assign t5_da   = $signed({1'b0, t4_g_q.a});
  assign t5_dz   = 66'(t4_g_q.dz);

  always_comb begin
    t5_dene_d = t5_dz;
    t5_denx_d = t5_dz;
    if (t4_g_q.axial) begin
      if (!t4_g_q.dz[32]) begin
        t5_nume_d = t5_capb;
        t5_numx_d = t5_capt;
        t5_fin_d  = FACE_BOTTOM;
        t5_fout_d = FACE_TOP;
      end else begin
        t5_nume_d = t5_capt;
        t5_numx_d = t5_capb;
        t5_fin_d  = FACE_TOP;
        t5_fout_d = FACE_BOTTOM;
      end
    end else begin
      if (t5_zeg) begin
        t5_nume_d = t5_capt;
        t5_fin_d  = FACE_TOP;
      end else if (t5_zen) begin
        t5_nume_d = t5_capb;
        t5_fin_d  = FACE_BOTTOM;
      end else begin
        t5_nume_d = t4_net_q;
        t5_dene_d = t5_da;
        t5_fin_d  = FACE_SIDE;
      end
      if (t5_zxg) begin
        t5_numx_d = t5_capt;
        t5_fout_d = FACE_TOP;
      end else if (t5_zxn) begin
        t5_numx_d = t5_capb;
        t5_fout_d = FACE_BOTTOM;
      end else begin
        t5_numx_d = t4_nxt_q;
        t5_denx_d = t5_da;
        t5_fout_d = FACE_SIDE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t5_nume_q     <= t5_nume_d;
      t5_numx_q     <= t5_numx_d;
      t5_dene_q     <= t5_dene_d;
      t5_denx_q     <= t5_denx_d;
      t5_res_q.hit  <= !(t4_g_q.miss || (!t4_g_q.axial &&
                         ((t5_zen && t5_zxn) || (t5_zeg && t5_zxg))));
      t5_res_q.t0   <= t4_g_q.t0;
      t5_res_q.fin  <= t5_fin_d;
      t5_res_q.fout <= t5_fout_d;
    end
  end

  // T6: magnitudes and quotient sign
  logic signed [99:0] t6_nne, t6_nnx;
  logic signed [65:0] t6_dne, t6_dnx;
  logic [99:0]        t6_nae_q, t6_nax_q;
  logic [64:0]        t6_dae_q, t6_dax_q;
  logic               t6_nge_q, t6_ngx_q;
  res_t               t6_res_q;

  assign t6_nne = -t5_nume_q;
  assign t6_nnx = -t5_numx_q;
  assign t6_dne = -t5_dene_q;
  assign t6_dnx = -t5_denx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t6_nae_q <= t5_nume_q[99] ? t6_nne : t5_nume_q;
      t6_nax_q <= t5_numx_q[99] ? t6_nnx : t5_numx_q;
      t6_dae_q <= t5_dene_q[65] ? t6_dne[64:0] : t5_dene_q[64:0];
      t6_dax_q <= t5_denx_q[65] ? t6_dnx[64:0] : t5_denx_q[64:0];
      t6_nge_q <= t5_nume_q[99] ^ t5_dene_q[65];
      t6_ngx_q <= t5_numx_q[99] ^ t5_denx_q[65];
      t6_res_q <= t5_res_q;
    end
  end

  // T7: range check, divider load
  div_t t7_e_d, t7_x_d, t7_e_q, t7_x_q;
  res_t t7_res_q;

  always_comb begin
    t7_e_d.neg   = t6_nge_q;
    t7_e_d.dzero = (t6_dae_q == '0);
    t7_e_d.ovf   = !t7_e_d.dzero && (t6_nae_q[99:33] >= 67'(t6_dae_q));
    t7_e_d.den   = t6_dae_q;
    t7_e_d.nlo   = t6_nae_q[QB-1:0];
    t7_e_d.rem   = (t7_e_d.ovf || t7_e_d.dzero) ? '0 : t6_nae_q[97:33];
    t7_e_d.quo   = '0;
    t7_x_d.neg   = t6_ngx_q;
    t7_x_d.dzero = (t6_dax_q == '0);
    t7_x_d.ovf   = !t7_x_d.dzero && (t6_nax_q[99:33] >= 67'(t6_dax_q));
    t7_x_d.den   = t6_dax_q;
    t7_x_d.nlo   = t6_nax_q[QB-1:0];
    t7_x_d.rem   = (t7_x_d.ovf || t7_x_d.dzero) ? '0 : t6_nax_q[97:33];
    t7_x_d.quo   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t7_e_q   <= t7_e_d;
      t7_x_q   <= t7_x_d;
      t7_res_q <= t6_res_q;
    end
  end

  // restoring dividers, one quotient bit per stage
  div_t dv_e_q [QB];
  div_t dv_x_q [QB];
  res_t dv_r_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    div_t ein, xin;
    res_t rin;
    if (j == 0) begin : g_first
      assign ein = t7_e_q;
      assign xin = t7_x_q;
      assign rin = t7_res_q;
    end else begin : g_next
      assign ein = dv_e_q[j-1];
      assign xin = dv_x_q[j-1];
      assign rin = dv_r_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_e_q[j] <= div_step(ein, QB - 1 - j);
        dv_x_q[j] <= div_step(xin, QB - 1 - j);
        dv_r_q[j] <= rin;
      end
    end
  end

  // F1: floor correction
  logic signed [34:0] f1_qe_q, f1_qx_q;
  res_t               f1_res_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_qe_q  <= quo_fix(dv_e_q[QB-1]);
      f1_qx_q  <= quo_fix(dv_x_q[QB-1]);
      f1_res_q <= dv_r_q[QB-1];
    end
  end

  // F2: add start time, saturate, output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_o         <= f1_res_q.hit;
      entry_param_o <= f1_res_q.hit ? sat32(f1_res_q.t0, f1_qe_q) : '0;
      exit_param_o  <= f1_res_q.hit ? sat32(f1_res_q.t0, f1_qx_q) : '0;
      entry_face_o  <= f1_res_q.hit ? f1_res_q.fin : FACE_BOTTOM;
      exit_face_o   <= f1_res_q.hit ? f1_res_q.fout : FACE_BOTTOM;
    end
  end

endmodule

FILE: rtl/scch_checker.sv
// ----------------------------------------------------------------------------
// scch_checker
// Port-level checks for the capped cylinder hit core, bound to the top level.
// ----------------------------------------------------------------------------
module scch_checker import scch_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               hit_o,
  input logic signed [31:0] entry_param_o,
  input logic signed [31:0] exit_param_o,
  input logic [1:0]         entry_face_o,
  input logic [1:0]         exit_face_o
);

  // a miss carries an all-zero result
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> entry_param_o == '0 && exit_param_o == '0 &&
      entry_face_o == FACE_BOTTOM && exit_face_o == FACE_BOTTOM)
    else $error("miss with nonzero result");

  // only the side can be both entered and left
  a_same_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o && entry_face_o == exit_face_o |->
      entry_face_o == FACE_SIDE)
    else $error("entry and exit on the same cap");

  // input backpressure only comes from a held output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o) &&
      $stable(entry_param_o) && $stable(exit_param_o))
    else $error("stalled item changed");

endmodule

bind segment_capped_cylinder_hit_core scch_checker u_scch_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Capped cylinder hit core testbench
// Feeds line segments through the valid/stall input, checks every result
// against a built-in predictor of the intersection with the unit cylinder,
// under random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import scch_pkg::*;

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic signed [31:0] sx, sy, sz, ex, ey, ez, tp0, tp1;
  } segment_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] t_in;
    logic signed [31:0] t_out;
    face_e              f_in;
    face_e              f_out;
  } crossing_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] start_x_i, start_y_i, start_z_i;
  logic signed [31:0] end_x_i, end_y_i, end_z_i;
  logic signed [31:0] start_param_i, end_param_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               hit_o;
  logic signed [31:0] entry_param_o, exit_param_o;
  logic [1:0]         entry_face_o, exit_face_o;

  segment_t  pending_segs[$];
  crossing_t expected_crossings[$];
  int        accepted_cnt;
  int        mismatch_cnt;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        holdoff_cnt;
  bit        holdoff_req;
  bit        holdoff_done;

  segment_capped_cylinder_hit_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic wide_t div_floor(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [31:0] sat32(wide_t v);
    if (v > 160'sd2147483647) return 32'sh7fffffff;
    if (v < -160'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic wide_t cap_cross(wide_t h, wide_t z0, wide_t dz, wide_t t0, wide_t dt);
    return t0 + div_floor((h - z0) * dt, dz);
  endfunction

  function automatic crossing_t cylinder_crossing(segment_t s);
    crossing_t res;
    wide_t x0, y0, z0, dx, dy, dz, t0, dt, a, c, k, q, r, cand, b, ne, nx, ze, zx, za, one;
    wide_t tin, tout;
    face_e fin, fout;
    res = '{hit: 1'b0, t_in: '0, t_out: '0, f_in: FACE_BOTTOM, f_out: FACE_BOTTOM};
    x0 = s.sx; y0 = s.sy; z0 = s.sz; t0 = s.tp0;
    dx = wide_t'(s.ex) - x0;
    dy = wide_t'(s.ey) - y0;
    dz = wide_t'(s.ez) - z0;
    dt = wide_t'(s.tp1) - t0;
    if (dt == 0) return res;
    a = dx * dx + dy * dy;
    c = x0 * x0 + y0 * y0 - (160'sd1 <<< 32);
    if (a == 0) begin
      if (c > 0 || dz == 0) return res;
      if (dz > 0) begin
        tin = cap_cross(0, z0, dz, t0, dt); tout = cap_cross(65536, z0, dz, t0, dt);
        fin = FACE_BOTTOM; fout = FACE_TOP;
      end else begin
        tin = cap_cross(65536, z0, dz, t0, dt); tout = cap_cross(0, z0, dz, t0, dt);
        fin = FACE_TOP; fout = FACE_BOTTOM;
      end
    end else begin
      k = x0 * dy - y0 * dx;
      if (k >= (160'sd1 <<< 50) || -k >= (160'sd1 <<< 50)) return res;
      q = (a <<< 32) - k * k;
      if (q < 0) return res;
      r = 0;
      for (int i = 62; i >= 0; i--) begin
        cand = r | (160'sd1 <<< i);
        if (cand * cand <= q) r = cand;
      end
      b = x0 * dx + y0 * dy;
      ne = -b - r;
      nx = -b + r;
      za = z0 * a;
      ze = za + ne * dz;
      zx = za + nx * dz;
      one = a <<< 16;
      if (ze < 0 && zx < 0) return res;
      if (ze > one && zx > one) return res;
      tin = t0 + div_floor(ne * dt, a);
      tout = t0 + div_floor(nx * dt, a);
      fin = FACE_SIDE;
      fout = FACE_SIDE;
      if (ze > one) begin
        fin = FACE_TOP; tin = cap_cross(65536, z0, dz, t0, dt);
      end else if (ze < 0) begin
        fin = FACE_BOTTOM; tin = cap_cross(0, z0, dz, t0, dt);
      end
      if (zx > one) begin
        fout = FACE_TOP; tout = cap_cross(65536, z0, dz, t0, dt);
      end else if (zx < 0) begin
        fout = FACE_BOTTOM; tout = cap_cross(0, z0, dz, t0, dt);
      end
    end
    res.hit = 1'b1;
    res.t_in = sat32(tin);
    res.t_out = sat32(tout);
    res.f_in = fin;
    res.f_out = fout;
    return res;
  endfunction

  function automatic logic signed [31:0] near_coord();
    return $urandom_range(393216) - 196608;
  endfunction

  function automatic logic signed [31:0] any_word();
    case ($urandom_range(3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_seg(int sx, int sy, int sz, int ex, int ey, int ez, int tp0, int tp1);
    segment_t s;
    s = '{sx: sx, sy: sy, sz: sz, ex: ex, ey: ey, ez: ez, tp0: tp0, tp1: tp1};
    pending_segs.push_back(s);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      {start_x_i, start_y_i, start_z_i, end_x_i, end_y_i, end_z_i} <= '0;
      {start_param_i, end_param_i} <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        expected_crossings.push_back(cylinder_crossing('{sx: start_x_i, sy: start_y_i,
          sz: start_z_i, ex: end_x_i, ey: end_y_i, ez: end_z_i, tp0: start_param_i,
          tp1: end_param_i}));
        accepted_cnt++;
      end
      if (pending_segs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        segment_t s;
        s = pending_segs.pop_front();
        in_valid_i <= 1'b1;
        start_x_i <= s.sx; start_y_i <= s.sy; start_z_i <= s.sz;
        end_x_i <= s.ex; end_y_i <= s.ey; end_z_i <= s.ez;
        start_param_i <= s.tp0; end_param_i <= s.tp1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long output hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_cnt <= 0;
      holdoff_done <= 1'b0;
    end else if (holdoff_req && !holdoff_done) begin
      holdoff_cnt <= 400;
      holdoff_done <= 1'b1;
    end else if (holdoff_cnt != 0) begin
      holdoff_cnt <= holdoff_cnt - 1;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= (holdoff_cnt > 1) || ($urandom_range(99) < recv_stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (expected_crossings.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result item");
        end else begin
          crossing_t e;
          e = expected_crossings.pop_front();
          if (hit_o !== e.hit || entry_param_o !== e.t_in || exit_param_o !== e.t_out ||
              entry_face_o !== e.f_in || exit_face_o !== e.f_out) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: exp hit=%0b in=%0d out=%0d fin=%0d fout=%0d, got %0b %0d %0d %0d %0d",
                       e.hit, e.t_in, e.t_out, e.f_in, e.f_out, hit_o, entry_param_o,
                       exit_param_o, entry_face_o, exit_face_o);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int total;
    rst_ni = 1'b0;
    send_idle_pct = 27;
    recv_stall_pct = 81;
    holdoff_req = 1'b0;
    accepted_cnt = 0;
    mismatch_cnt = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_seg(0, 0, 0, 65536, 0, 0, 1000, 1000);
    add_seg(0, 0, -65536, 0, 0, 131072, 0, 65536);
    add_seg(32768, 0, 131072, 32768, 0, -65536, 0, 65536);
    add_seg(131072, 0, 0, 131072, 0, 65536, 0, 65536);
    add_seg(0, 0, 32768, 0, 0, 32768, 0, 65536);
    add_seg(-131072, 65536, 32768, 131072, 65536, 32768, 0, 65536);
    add_seg(-131072, 0, 32768, 131072, 0, 32768, 0, 65536);
    add_seg(-131072, 0, 32768, 131072, 0, 32768, 65536, 0);
    add_seg(-131072, 0, -65536, 131072, 0, -32768, 0, 65536);
    add_seg(-131072, 0, 131072, 131072, 0, 196608, 0, 65536);
    add_seg(-131072, 0, -65536, 131072, 0, 131072, 0, 65536);
    add_seg(-131072, 131072, 32768, 131072, 131072, 32768, 0, 65536);
    add_seg(0, 0, 0, 0, 0, 1, 0, 32'sh7fffffff);
    add_seg(0, 0, 0, 0, 0, 1, 0, 32'sh80000000);
    add_seg(-65536, 0, 32768, -65535, 0, 32768, 32'sh80000000, 32'sh7fffffff);
    add_seg(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
            32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    add_seg(32'sh80000000, 0, 0, 32'sh7fffffff, 1, 1, 32'sh80000000, 32'sh7fffffff);
    add_seg(-1, -1, -1, 1, 1, 1, -1, 1);
    add_seg(0, 0, 0, 0, 0, 0, 0, 65536);

    for (int n = 0; n < 1250; n++) begin
      segment_t s;
      case ($urandom_range(9))
        0, 1: s = '{any_word(), any_word(), any_word(), any_word(), any_word(),
                    any_word(), any_word(), any_word()};
        2: begin
          s.sx = $urandom_range(131072) - 65536; s.sy = $urandom_range(131072) - 65536;
          s.ex = s.sx; s.ey = s.sy;
          s.sz = near_coord(); s.ez = near_coord();
          s.tp0 = $urandom; s.tp1 = $urandom;
        end
        default: begin
          s = '{near_coord(), near_coord(), near_coord(), near_coord(), near_coord(),
                near_coord(), near_coord(), near_coord()};
          if ($urandom_range(3) == 0) s.tp1 = $urandom;
        end
      endcase
      pending_segs.push_back(s);
    end
    total = pending_segs.size();

    wait (accepted_cnt >= total / 3);
    holdoff_req = 1'b1;
    send_idle_pct = 81;
    recv_stall_pct = 27;
    wait (accepted_cnt >= 2 * total / 3);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait (pending_segs.size() == 0 && !in_valid_i);
    wait (expected_crossings.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_crossings.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/scch_pkg.sv
rtl/segment_capped_cylinder_hit_core.sv
rtl/scch_checker.sv
bench/testbench.sv
